[rtl/hlfp_pkg.sv]
// Package for the hex line frame parser: widths, line constants, the
// line classification struct and the hex digit decode function.
// No dependencies.
package hlfp_pkg;

   localparam int TEXT_W          = 64;
   localparam int ENDING_W        = 16;
   localparam int VALUE_W         = 16;
   localparam int CHARS           = TEXT_W / 8;
   localparam int DATA_LINES_DFLT = 7;

   // Start and end marker text, first character in the top byte.
   localparam logic [TEXT_W-1:0]   START_TEXT = 64'h3030_3030_3030_3562;
   localparam logic [TEXT_W-1:0]   END_TEXT   = 64'h3030_3030_3030_3564;
   // Proper line ending: LF then CR.
   localparam logic [ENDING_W-1:0] GOOD_END   = 16'h0A0D;

   // Data line numbers whose values travel in a frame.
   localparam int SLOT_ONE   = 1;
   localparam int SLOT_THREE = 3;
   localparam int SLOT_FOUR  = 4;
   localparam int SLOT_FIVE  = 5;

   typedef struct packed {
      logic               is_start;
      logic               is_end;
      logic               is_data;
      logic [VALUE_W-1:0] data_value;
   } line_class_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] nibble;
   } hex_digit_type;

   // Decodes one ASCII character as a hex digit (0-9, a-f, A-F).
   function automatic hex_digit_type hex_digit(input logic [7:0] c);
      hex_digit_type d;
      d.ok     = 1'b0;
      d.nibble = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.ok     = 1'b1;
         d.nibble = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         d.ok     = 1'b1;
         d.nibble = 4'(c[3:0] + 4'd9);
      end
      return d;
   endfunction

endpackage

[rtl/hlfp_req_if.sv]
// Request channel interface: valid/ready handshake with one text line.
// Depends on hlfp_pkg.
interface hlfp_req_if;
   logic                         valid;
   logic                         ready;
   logic [hlfp_pkg::TEXT_W-1:0]   line_text;
   logic [hlfp_pkg::ENDING_W-1:0] line_ending;

   modport source (output valid, output line_text, output line_ending, input ready);
   modport sink   (input valid, input line_text, input line_ending, output ready);
endinterface

[rtl/hlfp_rsp_if.sv]
// Response channel interface: valid/ready handshake with a frame or a
// resend request. Depends on hlfp_pkg.
interface hlfp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        frame_ok;
   logic                        resend_request;
   logic [hlfp_pkg::VALUE_W-1:0] value_one;
   logic [hlfp_pkg::VALUE_W-1:0] value_three;
   logic [hlfp_pkg::VALUE_W-1:0] value_four;
   logic [hlfp_pkg::VALUE_W-1:0] value_five;

   modport source (output valid, output frame_ok, output resend_request,
                   output value_one, output value_three, output value_four,
                   output value_five, input ready);
   modport sink   (input valid, input frame_ok, input resend_request,
                   input value_one, input value_three, input value_four,
                   input value_five, output ready);
endinterface

[rtl/hex_line_frame_parser.sv]
// Top level of the hex line frame parser: input register, line decode,
// frame position counter, value capture and response register.
// Depends on hlfp_pkg, hlfp_req_if, hlfp_rsp_if and hlfp_line_decode.
//
//   Channel  Direction  Payload                                   Handshake
//   req_if   in         line_text, line_ending                    valid/ready
//   rsp_if   out        frame_ok, resend_request, four values     valid/ready
//
// A request is registered on acceptance and decoded in the following cycle,
// and the response it makes is registered in the response register. A new
// request can be accepted every cycle while the stage does not stall. Only the
// end-position line makes a response; all other lines just move the frame
// position. The stage stalls only when it holds an end-position line and the
// response register is full and not being drained. Reset is synchronous and
// returns the parser to hunting for the start line with both stages empty.
module hex_line_frame_parser #(
   parameter int DATA_LINES = hlfp_pkg::DATA_LINES_DFLT
) (
   input  logic       clock,
   input  logic       reset,
   hlfp_req_if.sink   req_if,
   hlfp_rsp_if.source rsp_if
);

   // Position 0 hunts, 1..DATA_LINES waits for that data line, and
   // DATA_LINES+1 waits for the end line.
   localparam int              POS_W     = $clog2(DATA_LINES + 2);
   localparam logic [POS_W-1:0] LAST_DATA = POS_W'(DATA_LINES);
   localparam logic [POS_W-1:0] POS_ONE   = POS_W'(hlfp_pkg::SLOT_ONE);
   localparam logic [POS_W-1:0] POS_THREE = POS_W'(hlfp_pkg::SLOT_THREE);
   localparam logic [POS_W-1:0] POS_FOUR  = POS_W'(hlfp_pkg::SLOT_FOUR);
   localparam logic [POS_W-1:0] POS_FIVE  = POS_W'(hlfp_pkg::SLOT_FIVE);

   // Input register stage.
   logic                          line_valid_ff, line_valid_in;
   logic [hlfp_pkg::TEXT_W-1:0]   line_text_ff;
   logic [hlfp_pkg::ENDING_W-1:0] line_ending_ff;

   // Frame state and captured values.
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic [hlfp_pkg::VALUE_W-1:0]  val_one_ff, val_three_ff, val_four_ff, val_five_ff;

   // Response register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          frame_ok_ff, resend_ff;
   logic [hlfp_pkg::VALUE_W-1:0]  out_one_ff, out_three_ff, out_four_ff, out_five_ff;

   hlfp_pkg::line_class_type      line_class;
   logic                          at_hunt, at_data, at_end;
   logic                          out_free, advance, req_accept, capture;

   hlfp_line_decode u_decode (
      .line_text   (line_text_ff),
      .line_ending (line_ending_ff),
      .line_class  (line_class)
   );

   assign at_hunt = (pos_ff == '0);
   assign at_data = !at_hunt && (pos_ff <= LAST_DATA);
   assign at_end  = !at_hunt && !at_data;

   // The response register can take a new response when it is empty or
   // its current response leaves in this cycle.
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign advance    = line_valid_ff && (!at_end || out_free);
   assign req_if.ready = !line_valid_ff || advance;
   assign req_accept = req_if.valid && req_if.ready;

   assign line_valid_in = req_accept || (line_valid_ff && !advance);
   assign capture       = advance && at_data && line_class.is_data;

   always_comb begin
      pos_in = pos_ff;
      if (advance) begin
         if (at_hunt) begin
            pos_in = line_class.is_start ? POS_W'(1) : '0;
         end else if (at_data) begin
            // A malformed data line drops the frame silently.
            pos_in = line_class.is_data ? POS_W'(pos_ff + POS_W'(1)) : '0;
         end else begin
            pos_in = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && at_end) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_valid_ff <= 1'b0;
         pos_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         line_valid_ff <= line_valid_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         line_text_ff   <= req_if.line_text;
         line_ending_ff <= req_if.line_ending;
      end
      // Only the data lines whose values travel in a frame are kept.
      if (capture && pos_ff == POS_ONE) begin
         val_one_ff <= line_class.data_value;
      end
      if (capture && pos_ff == POS_THREE) begin
         val_three_ff <= line_class.data_value;
      end
      if (capture && pos_ff == POS_FOUR) begin
         val_four_ff <= line_class.data_value;
      end
      if (capture && pos_ff == POS_FIVE) begin
         val_five_ff <= line_class.data_value;
      end
      // Any line other than the end marker at the end position asks for a
      // resend, and the values then read as zero.
      if (advance && at_end) begin
         frame_ok_ff  <= line_class.is_end;
         resend_ff    <= !line_class.is_end;
         out_one_ff   <= line_class.is_end ? val_one_ff   : '0;
         out_three_ff <= line_class.is_end ? val_three_ff : '0;
         out_four_ff  <= line_class.is_end ? val_four_ff  : '0;
         out_five_ff  <= line_class.is_end ? val_five_ff  : '0;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.frame_ok       = frame_ok_ff;
   assign rsp_if.resend_request = resend_ff;
   assign rsp_if.value_one      = out_one_ff;
   assign rsp_if.value_three    = out_three_ff;
   assign rsp_if.value_four     = out_four_ff;
   assign rsp_if.value_five     = out_five_ff;

endmodule

[rtl/hlfp_line_decode.sv]
// Combinational line classifier: start marker, end marker, or a valid
// eight-digit hex data line with its low 16 bits. Depends on hlfp_pkg.
module hlfp_line_decode (
   input  logic [hlfp_pkg::TEXT_W-1:0]   line_text,
   input  logic [hlfp_pkg::ENDING_W-1:0] line_ending,
   output hlfp_pkg::line_class_type      line_class
);

   hlfp_pkg::hex_digit_type digits [hlfp_pkg::CHARS];
   logic [hlfp_pkg::CHARS-1:0] digit_ok;
   logic                       ending_ok;

   always_comb begin
      for (int i = 0; i < hlfp_pkg::CHARS; i++) begin
         digits[i]   = hlfp_pkg::hex_digit(line_text[8*i +: 8]);
         digit_ok[i] = digits[i].ok;
      end
   end

   assign ending_ok = (line_ending == hlfp_pkg::GOOD_END);

   always_comb begin
      line_class.is_start   = ending_ok && (line_text == hlfp_pkg::START_TEXT);
      line_class.is_end     = ending_ok && (line_text == hlfp_pkg::END_TEXT);
      line_class.is_data    = ending_ok && (&digit_ok);
      // The last four characters carry the low 16 bits of the value.
      line_class.data_value = {digits[3].nibble, digits[2].nibble,
                               digits[1].nibble, digits[0].nibble};
   end

endmodule

[tb/hlfp_frame_checker.sv]
`timescale 1ns / 1ps
// Frame checker for the hex line frame parser: follows the frame position of
// every accepted request, predicts each response and compares it on arrival.
// Depends on hlfp_pkg, hlfp_req_if and hlfp_rsp_if.
module hlfp_frame_checker #(
   parameter int DATA_LINES = hlfp_pkg::DATA_LINES_DFLT
) (
   input  logic clock,
   input  logic reset,
   hlfp_req_if  req_mon,
   hlfp_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   frames_pending
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic                         frame_ok;
      logic                         resend_request;
      logic [hlfp_pkg::VALUE_W-1:0] value_one;
      logic [hlfp_pkg::VALUE_W-1:0] value_three;
      logic [hlfp_pkg::VALUE_W-1:0] value_four;
      logic [hlfp_pkg::VALUE_W-1:0] value_five;
   } frame_outcome_type;

   frame_outcome_type            expected_frames[$];
   logic [hlfp_pkg::VALUE_W-1:0] captured_values[DATA_LINES];
   int unsigned                  line_slot = 0;
   int                           mismatches = 0;

   // Returns 1 when all eight characters are hex digits; low_bits gets the
   // value of the last four characters.
   function automatic bit decode_data_text(input logic [hlfp_pkg::TEXT_W-1:0] text,
                                           output logic [hlfp_pkg::VALUE_W-1:0] low_bits);
      logic [7:0] c;
      logic [3:0] nib;
      bit         all_hex;
      all_hex  = 1'b1;
      low_bits = '0;
      for (int i = 0; i < hlfp_pkg::CHARS; i++) begin
         c = text[8*i +: 8];
         if (c >= 8'h30 && c <= 8'h39) begin
            nib = 4'(c - 8'h30);
         end else if (c >= 8'h61 && c <= 8'h66) begin
            nib = 4'(c - 8'h61 + 8'd10);
         end else if (c >= 8'h41 && c <= 8'h46) begin
            nib = 4'(c - 8'h41 + 8'd10);
         end else begin
            nib     = '0;
            all_hex = 1'b0;
         end
         if (i < hlfp_pkg::VALUE_W / 4) begin
            low_bits[4*i +: 4] = nib;
         end
      end
      return all_hex;
   endfunction

   // Advances the frame position by one line and queues the response that
   // an end-position line produces.
   function automatic void follow_line(input logic [hlfp_pkg::TEXT_W-1:0] text,
                                       input logic [hlfp_pkg::ENDING_W-1:0] ending);
      frame_outcome_type            outcome;
      logic [hlfp_pkg::VALUE_W-1:0] value;
      if (line_slot == 0) begin
         if (text == hlfp_pkg::START_TEXT && ending == hlfp_pkg::GOOD_END) begin
            line_slot = 1;
         end
      end else if (line_slot <= DATA_LINES) begin
         if (ending == hlfp_pkg::GOOD_END && decode_data_text(text, value)) begin
            captured_values[line_slot-1] = value;
            line_slot++;
         end else begin
            line_slot = 0;
         end
      end else begin
         outcome = '0;
         if (text == hlfp_pkg::END_TEXT && ending == hlfp_pkg::GOOD_END) begin
            outcome.frame_ok    = 1'b1;
            outcome.value_one   = captured_values[hlfp_pkg::SLOT_ONE-1];
            outcome.value_three = captured_values[hlfp_pkg::SLOT_THREE-1];
            outcome.value_four  = captured_values[hlfp_pkg::SLOT_FOUR-1];
            outcome.value_five  = captured_values[hlfp_pkg::SLOT_FIVE-1];
         end else begin
            outcome.resend_request = 1'b1;
         end
         expected_frames.push_back(outcome);
         line_slot = 0;
      end
   endfunction

   function automatic void check_response(input frame_outcome_type seen);
      frame_outcome_type want;
      if (expected_frames.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: response with nothing pending: ok=%b resend=%b", $time,
                     seen.frame_ok, seen.resend_request);
         end
      end else begin
         want = expected_frames.pop_front();
         if (seen.frame_ok !== want.frame_ok || seen.resend_request !== want.resend_request
             || seen.value_one !== want.value_one || seen.value_three !== want.value_three
             || seen.value_four !== want.value_four || seen.value_five !== want.value_five)
         begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: response differs, expected ok=%b resend=%b %h %h %h %h",
                        $time, want.frame_ok, want.resend_request, want.value_one,
                        want.value_three, want.value_four, want.value_five);
               $display("%0t:                   actual   ok=%b resend=%b %h %h %h %h",
                        $time, seen.frame_ok, seen.resend_request, seen.value_one,
                        seen.value_three, seen.value_four, seen.value_five);
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         line_slot = 0;
         expected_frames.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_response({rsp_mon.frame_ok, rsp_mon.resend_request, rsp_mon.value_one,
                            rsp_mon.value_three, rsp_mon.value_four, rsp_mon.value_five});
         end
         if (req_mon.valid && req_mon.ready) begin
            follow_line(req_mon.line_text, req_mon.line_ending);
         end
      end
      mismatch_count <= mismatches;
      frames_pending <= expected_frames.size();
   end

endmodule

[tb/tb_hex_line_frame_parser.sv]
`timescale 1ns / 1ps
// Top of the hex line frame parser testbench: clock, reset, line stimulus,
// response back-pressure and the verdict. Depends on hlfp_pkg, both channel
// interfaces, hex_line_frame_parser and hlfp_frame_checker.
module tb_hex_line_frame_parser;

   localparam int DATA_LINES  = hlfp_pkg::DATA_LINES_DFLT;
   localparam int TEXT_W      = hlfp_pkg::TEXT_W;
   localparam int ENDING_W    = hlfp_pkg::ENDING_W;
   localparam int CHARS       = hlfp_pkg::CHARS;
   // Lines in well-formed or broken frames; plain noise is not counted.
   localparam int LINE_TARGET = 1850;
   localparam int MID_PAUSE   = 1200;
   localparam int IDLE_PCT    = 6;
   localparam int RUN_LIMIT   = 200_000;
   localparam int TAIL_CYCLES = 10;

   // The sender never idles while lines_sent is inside this window.
   localparam int SEND_STEADY_FROM  = 700;
   localparam int SEND_STEADY_UNTIL = 1000;
   // Receiver windows in cycles: a long hold-off and a stretch always ready.
   localparam int HOLD_FROM         = 800;
   localparam int HOLD_UNTIL        = 1100;
   localparam int RECV_STEADY_FROM  = 1500;
   localparam int RECV_STEADY_UNTIL = 1900;

   typedef enum int {CASE_LOWER, CASE_UPPER, CASE_MIXED} digit_case_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int          mismatch_count;
   int          frames_pending;
   int unsigned lines_sent = 0;
   int unsigned counted_lines = 0;
   int unsigned run_cycles = 0;
   int unsigned rx_cycles = 0;
   bit          mid_pause_done = 1'b0;

   always #5 clock = ~clock;

   hlfp_req_if req_if();
   hlfp_rsp_if rsp_if();

   hex_line_frame_parser #(
      .DATA_LINES(DATA_LINES)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   hlfp_frame_checker #(
      .DATA_LINES(DATA_LINES)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .mismatch_count(mismatch_count),
      .frames_pending(frames_pending)
   );

   // One ASCII hex digit. In mixed style each letter picks its case at random,
   // so both letter ranges show up inside a single line.
   function automatic logic [7:0] hex_char(input logic [3:0] nib,
                                           input digit_case_type style);
      logic upper;
      upper = (style == CASE_UPPER) || (style == CASE_MIXED && $urandom_range(0, 1) == 1);
      if (nib < 4'd10) begin
         return 8'(8'h30 + nib);
      end
      return 8'((upper ? 8'h41 : 8'h61) + nib - 8'd10);
   endfunction

   // Eight hex digits of a 32-bit value, first digit in the top byte.
   function automatic logic [TEXT_W-1:0] data_text(input logic [31:0] value,
                                                   input digit_case_type style);
      logic [TEXT_W-1:0] text;
      for (int i = 0; i < CHARS; i++) begin
         text[8*i +: 8] = hex_char(value[4*i +: 4], style);
      end
      return text;
   endfunction

   // A character that is not a hex digit. Half of the time it is one that
   // sits right beside a digit range, or whitespace, a sign or the x of a
   // prefix; otherwise any other byte.
   function automatic logic [7:0] stray_char();
      logic [7:0] c;
      if ($urandom_range(0, 1) == 1) begin
         case ($urandom_range(0, 9))
            0:       c = 8'h20;   // space
            1:       c = 8'h2B;   // plus sign
            2:       c = 8'h2D;   // minus sign
            3:       c = 8'h78;   // x of a 0x prefix
            4:       c = 8'h2F;   // just below 0
            5:       c = 8'h3A;   // just above 9
            6:       c = 8'h40;   // just below A
            7:       c = 8'h47;   // just above F
            8:       c = 8'h60;   // just below a
            default: c = 8'h67;   // just above f
         endcase
         return c;
      end
      do begin
         c = 8'($urandom);
      end while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
                 || (c >= 8'h61 && c <= 8'h66));
      return c;
   endfunction

   // Any line ending other than LF, CR; the swapped order comes up often.
   function automatic logic [ENDING_W-1:0] wrong_ending();
      logic [ENDING_W-1:0] e;
      e = ($urandom_range(0, 1) == 1) ? 16'h0D0A : 16'($urandom);
      if (e == hlfp_pkg::GOOD_END) begin
         e = 16'h0A0A;
      end
      return e;
   endfunction

   // Offers one request and holds it until the parser takes it. An idle gap
   // is decided up front so that valid gets only one assignment per edge.
   task automatic send_line(input logic [TEXT_W-1:0] text, input logic [ENDING_W-1:0] ending);
      int unsigned gap;
      gap = 0;
      if (lines_sent < SEND_STEADY_FROM || lines_sent >= SEND_STEADY_UNTIL) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            gap++;
         end
      end
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.line_text   <= text;
      req_if.line_ending <= ending;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      lines_sent++;
   endtask

   // Start line followed by a number of good data lines with random values.
   task automatic send_frame_head(input int unsigned good_lines);
      send_line(hlfp_pkg::START_TEXT, hlfp_pkg::GOOD_END);
      repeat (good_lines) send_line(data_text($urandom, CASE_MIXED), hlfp_pkg::GOOD_END);
   endtask

   // Stops offering requests until every predicted response has come back.
   // At least one edge passes so valid is not raised again in the same step.
   task automatic drain_frames();
      req_if.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (frames_pending != 0);
   endtask

   // Receiver: random stalls, one long hold-off that lets the response
   // register fill and back the parser up into the request channel, and a
   // stretch where it never stalls.
   always @(posedge clock) begin
      rx_cycles++;
      if (rx_cycles >= HOLD_FROM && rx_cycles < HOLD_UNTIL) begin
         rsp_if.ready <= 1'b0;
      end else if (rx_cycles >= RECV_STEADY_FROM && rx_cycles < RECV_STEADY_UNTIL) begin
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      run_cycles++;
      if (run_cycles > RUN_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      logic [TEXT_W-1:0] text;
      int unsigned       pick;
      int unsigned       good_lines;
      int unsigned       pos;

      req_if.valid       = 1'b0;
      req_if.line_text   = '0;
      req_if.line_ending = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part. While hunting, noise and a start line with its ending
      // swapped are both ignored.
      send_line({TEXT_W{1'b1}}, {ENDING_W{1'b1}});
      send_line(hlfp_pkg::START_TEXT, 16'h0D0A);
      // A good frame whose data lines include the extreme values, in upper,
      // lower and mixed case.
      send_line(hlfp_pkg::START_TEXT, hlfp_pkg::GOOD_END);
      send_line(data_text(32'h0000_0000, CASE_UPPER), hlfp_pkg::GOOD_END);
      send_line(data_text(32'hFFFF_FFFF, CASE_UPPER), hlfp_pkg::GOOD_END);
      send_line(data_text(32'hFFFF_FFFF, CASE_LOWER), hlfp_pkg::GOOD_END);
      send_line(data_text(32'h1234_5678, CASE_MIXED), hlfp_pkg::GOOD_END);
      send_line(data_text(32'hABCD_EF09, CASE_LOWER), hlfp_pkg::GOOD_END);
      send_line(data_text(32'h0000_FFFF, CASE_UPPER), hlfp_pkg::GOOD_END);
      send_line(data_text(32'hFFFF_0000, CASE_LOWER), hlfp_pkg::GOOD_END);
      send_line(hlfp_pkg::END_TEXT, hlfp_pkg::GOOD_END);
      // The end text with a bad ending in the end position asks for a resend.
      send_frame_head(DATA_LINES);
      send_line(hlfp_pkg::END_TEXT, 16'h0000);
      // A data line with a wrong ending drops the parser back to hunting.
      send_line(hlfp_pkg::START_TEXT, hlfp_pkg::GOOD_END);
      send_line(data_text($urandom, CASE_MIXED), 16'h0D0A);
      // So does a data line with a 0x prefix.
      send_line(hlfp_pkg::START_TEXT, hlfp_pkg::GOOD_END);
      send_line(64'h3078_3030_3030_3562, hlfp_pkg::GOOD_END);
      send_line('0, '0);
      drain_frames();

      // Random part: mostly complete frames with random content, mixed with broken
      // frames and with noise for the hunting state.
      while (counted_lines < LINE_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            send_frame_head(DATA_LINES);
            case ($urandom_range(0, 9))
               8:       send_line(hlfp_pkg::END_TEXT, wrong_ending());
               9: begin
                  // Anything else in the end position, a start line included,
                  // gives a resend and does not open a new frame.
                  case ($urandom_range(0, 2))
                     0: send_line(hlfp_pkg::START_TEXT, hlfp_pkg::GOOD_END);
                     1: send_line(hlfp_pkg::END_TEXT ^ (64'd1 << $urandom_range(0, 63)),
                                  hlfp_pkg::GOOD_END);
                     default: send_line({$urandom, $urandom}, hlfp_pkg::GOOD_END);
                  endcase
               end
               default: send_line(hlfp_pkg::END_TEXT, hlfp_pkg::GOOD_END);
            endcase
            counted_lines += DATA_LINES + 2;
         end else if (pick < 90) begin
            good_lines = $urandom_range(0, DATA_LINES - 1);
            send_frame_head(good_lines);
            if ($urandom_range(0, 1) == 1) begin
               send_line(data_text($urandom, CASE_MIXED), wrong_ending());
            end else begin
               text = data_text($urandom, CASE_MIXED);
               pos  = $urandom_range(0, CHARS - 1);
               text[8*pos +: 8] = stray_char();
               send_line(text, hlfp_pkg::GOOD_END);
            end
            counted_lines += good_lines + 2;
         end else if ($urandom_range(0, 2) == 0) begin
            // One bit away from a start line.
            send_line(hlfp_pkg::START_TEXT ^ (64'd1 << $urandom_range(0, 63)),
                      hlfp_pkg::GOOD_END);
         end else begin
            send_line({$urandom, $urandom}, 16'($urandom));
         end

         if (!mid_pause_done && counted_lines >= MID_PAUSE) begin
            mid_pause_done = 1'b1;
            drain_frames();
         end
      end

      drain_frames();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
